// File: rtl/ranked_top_k_lists_defines.svh
// ----------------------------------------------------------------------------
// ranked_top_k_lists_defines.svh
// Assertion macros used by the ranked list top module. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef RANKED_TOP_K_LISTS_DEFINES_SVH
`define RANKED_TOP_K_LISTS_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold on every clock edge outside reset
`define RTKL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rtkl assertion failed");
// Condition in one cycle implies a condition in the next one
`define RTKL_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("rtkl assertion failed");
`else
`define RTKL_ASSERT(lbl, clk, rst_n, prop)
`define RTKL_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt)
`endif

`endif

// File: rtl/rtkl_pkg.sv
// ----------------------------------------------------------------------------
// rtkl_pkg
// Shared types, codes and the area code table of the ranked list block.
// ----------------------------------------------------------------------------
package rtkl_pkg;

  // One ranked entry: count is the ranking key
  typedef struct packed {
    logic [15:0] count;
    logic [31:0] tag;
    logic [9:0]  board;
  } entry_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_UNKNOWN = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_t;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // List select codes for reads
  localparam logic [1:0] LIST_GLOBAL      = 2'd0;
  localparam logic [1:0] LIST_GLOBAL_FILT = 2'd1;
  localparam logic [1:0] LIST_AREA        = 2'd2;
  localparam logic [1:0] LIST_AREA_FILT   = 2'd3;

  // Area code characters: '0'..'9', 'G', 'N', 'H', 'A', 'C'
  localparam int CODE_TABLE_LEN = 15;
  localparam logic [7:0] CODE_TABLE [CODE_TABLE_LEN] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h47, 8'h4E, 8'h48, 8'h41, 8'h43
  };

  typedef struct packed {
    logic       hit;
    logic [3:0] row;
  } code_map_t;

  // Commands from the sequencer to one area store
  typedef struct packed {
    logic ins_go;   // start an insert walk over one row
    logic rd_go;    // read one slot
    logic wr_en;    // the walk may write this store
  } area_cmd_t;

  // Map an area code byte to its table row
  function automatic code_map_t map_code(input logic [7:0] code);
    code_map_t m;
    m = '0;
    for (int i = 0; i < CODE_TABLE_LEN; i++) begin
      if (CODE_TABLE[i] == code) begin
        m.hit = 1'b1;
        m.row = 4'(i);
      end
    end
    return m;
  endfunction

endpackage

// File: rtl/rtkl_glist.sv
// ----------------------------------------------------------------------------
// rtkl_glist
// Register-based ranked list; an insert shifts the slots after its place.
// ----------------------------------------------------------------------------
module rtkl_glist #(
  parameter  int DEPTH = 10,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ins,
  input  rtkl_pkg::entry_t   ins_entry,
  input  logic [IDX_W-1:0]   rd_idx,
  output rtkl_pkg::entry_t   rd_entry
);
  import rtkl_pkg::*;

  entry_t           list_r   [DEPTH];
  entry_t           list_nxt [DEPTH];
  entry_t           prev     [DEPTH];
  logic [DEPTH-1:0] ge;
  logic [DEPTH-1:0] ge_ext;

  // Slots with count >= new count form a prefix; the new word goes after it
  always_comb begin
    prev[0]   = ins_entry;
    ge_ext[0] = 1'b1;
    for (int j = 0; j < DEPTH; j++) begin
      ge[j] = (list_r[j].count >= ins_entry.count);
    end
    for (int j = 1; j < DEPTH; j++) begin
      ge_ext[j] = ge[j-1];
      prev[j]   = list_r[j-1];
    end
    for (int j = 0; j < DEPTH; j++) begin
      if (ge[j]) begin
        list_nxt[j] = list_r[j];
      end else if (ge_ext[j]) begin
        list_nxt[j] = ins_entry;
      end else begin
        list_nxt[j] = prev[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DEPTH; j++) begin
        list_r[j] <= '0;
      end
    end else if (ins) begin
      for (int j = 0; j < DEPTH; j++) begin
        list_r[j] <= list_nxt[j];
      end
    end
  end

  assign rd_entry = list_r[rd_idx];

endmodule

// File: rtl/rtkl_astore.sv
// ----------------------------------------------------------------------------
// rtkl_astore
// Per-area ranked rows in one synchronous memory. An insert walks the row
// slot by slot: read, compare, write back the carried word.
// ----------------------------------------------------------------------------
module rtkl_astore #(
  parameter  int AREA_DEPTH = 5,
  parameter  int AREA_COUNT = 15,
  localparam int ROW_W  = (AREA_COUNT > 1) ? $clog2(AREA_COUNT) : 1,
  localparam int SLOT_W = (AREA_DEPTH > 1) ? $clog2(AREA_DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rtkl_pkg::area_cmd_t  cmd,
  input  logic [ROW_W-1:0]     row,
  input  logic [SLOT_W-1:0]    slot,
  input  rtkl_pkg::entry_t     ins_entry,
  output logic                 done,
  output rtkl_pkg::entry_t     rd_entry
);
  import rtkl_pkg::*;

  localparam int MEM_DEPTH = AREA_COUNT * AREA_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CNT_W     = $clog2(AREA_DEPTH + 1);
  localparam logic [ADDR_W:0] ROW_STRIDE = (ADDR_W + 1)'(AREA_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_READ} state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      issue_r;
  logic                  pend_r;
  logic [SLOT_W-1:0]     pslot_r;
  entry_t                carry_r;
  logic                  placed_r;
  logic                  we_r;
  logic                  vld_r;
  logic [ROW_W-1:0]      row_r;
  logic [ADDR_W-1:0]     base_r;
  logic [AREA_COUNT-1:0] row_valid_r;

  entry_t                mem [MEM_DEPTH];
  entry_t                rdata_r;

  logic [ADDR_W:0]       row_prod;
  logic [ADDR_W-1:0]     row_base;
  entry_t                cur;
  logic                  shift;
  logic                  last;
  logic                  more;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;

  // Row base address and current slot word (empty row reads as zero)
  assign row_prod = (ADDR_W + 1)'(row) * ROW_STRIDE;
  assign row_base = row_prod[ADDR_W-1:0];
  assign cur      = vld_r ? rdata_r : '0;
  assign shift    = placed_r || (cur.count < carry_r.count);
  assign last     = pend_r && (pslot_r == SLOT_W'(AREA_DEPTH - 1));
  assign more     = (32'(issue_r) < AREA_DEPTH);

  // Memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = base_r + ADDR_W'(issue_r);
    if (cmd.rd_go) begin
      rd_en   = 1'b1;
      rd_addr = row_base + ADDR_W'(slot);
    end else if (state_r == ST_WALK && more) begin
      rd_en = 1'b1;
    end
  end

  assign wr_en   = (state_r == ST_WALK) && pend_r && shift && we_r;
  assign wr_addr = base_r + ADDR_W'(pslot_r);

  assign done     = (state_r == ST_READ) || (state_r == ST_WALK && last);
  assign rd_entry = cur;

  // Walk sequencer and row valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_r     <= '0;
      pend_r      <= 1'b0;
      placed_r    <= 1'b0;
      we_r        <= 1'b0;
      vld_r       <= 1'b0;
      row_valid_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (cmd.ins_go) begin
            state_r  <= ST_WALK;
            issue_r  <= '0;
            pend_r   <= 1'b0;
            placed_r <= 1'b0;
            we_r     <= cmd.wr_en;
            vld_r    <= row_valid_r[row];
            row_r    <= row;
            base_r   <= row_base;
            carry_r  <= ins_entry;
          end else if (cmd.rd_go) begin
            state_r <= ST_READ;
            vld_r   <= row_valid_r[row];
          end
        end
        ST_WALK: begin
          if (more) begin
            issue_r <= CNT_W'(issue_r + 1'b1);
            pend_r  <= 1'b1;
            pslot_r <= SLOT_W'(issue_r);
          end else begin
            pend_r <= 1'b0;
          end
          // Once placed, every later slot takes the word above it
          if (pend_r && shift) begin
            carry_r  <= cur;
            placed_r <= 1'b1;
            if (we_r) begin
              row_valid_r[row_r] <= 1'b1;
            end
          end
          if (last) begin
            state_r <= ST_IDLE;
          end
        end
        ST_READ: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Slot memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= carry_r;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/ranked_top_k_lists.sv
// ----------------------------------------------------------------------------
// ranked_top_k_lists
// Four ranked lists: global and filtered global top lists, and per-area
// rows of both kinds held in slot memories.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word is taken on a clock edge with start high and
//   busy low. in_operation selects insert or read of one ranked entry.
//   Result channel: out_valid is high for one cycle with the result word;
//   the receiver cannot stall, so every result is taken that cycle.
// Command flow (from acceptance to the result):
//   Insert with a known area code: a slot-serial walk over the area row
//   in memory, one slot read per cycle; each slot from the insert point
//   on is written with the carried word (the filtered row only on pass).
//   Area read: one memory read. Global read, unknown area code or
//   out-of-range rank: answered in the dispatch state. busy is high from
//   acceptance until the result is shown, so one command is in work at a
//   time; the next one may be started in the cycle that out_valid is high.
// Reset:
//   rst_n low clears every list to empty (count zero) at once; area rows
//   use a valid bit each, so no clearing pass runs. The block leaves
//   reset idle, ready to take a command.
// ----------------------------------------------------------------------------
`include "ranked_top_k_lists_defines.svh"

module ranked_top_k_lists #(
  parameter int GLOBAL_DEPTH = 10,
  parameter int AREA_DEPTH   = 5,
  parameter int AREA_COUNT   = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [15:0] in_thread_count,
  input  logic [31:0] in_thread_tag,
  input  logic [9:0]  in_board_id,
  input  logic [7:0]  in_area_code,
  input  logic        in_passes_filter,
  input  logic [1:0]  in_list_select,
  input  logic [3:0]  in_rank,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_entry_count,
  output logic [31:0] out_entry_tag,
  output logic [9:0]  out_entry_board
);
  import rtkl_pkg::*;

  localparam int ROW_W  = (AREA_COUNT > 1) ? $clog2(AREA_COUNT) : 1;
  localparam int SLOT_W = (AREA_DEPTH > 1) ? $clog2(AREA_DEPTH) : 1;
  localparam int GIDX_W = (GLOBAL_DEPTH > 1) ? $clog2(GLOBAL_DEPTH) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_DISPATCH, ST_WAIT} state_t;

  state_t      state_r;
  logic        op_r;
  entry_t      entry_r;
  logic        pass_r;
  logic [1:0]  sel_r;
  logic [3:0]  rank_r;
  logic        hit_r;
  logic [3:0]  row_r;

  logic        out_valid_r;
  status_t     out_status_r;
  entry_t      out_entry_r;

  code_map_t   in_map;
  logic        dispatch;
  logic        is_ins;
  logic        area_sel;
  logic        area_rank_ok;
  logic        glob_rank_ok;
  logic        glob_ins;
  logic        glob_f_ins;
  logic        area_rd;
  area_cmd_t   cmd_u;
  area_cmd_t   cmd_f;
  logic        done_u;
  logic        done_f;
  entry_t      g_rd;
  entry_t      gf_rd;
  entry_t      u_rd;
  entry_t      f_rd;
  entry_t      glob_sel_rd;

  assign in_map = map_code(in_area_code);

  // Command decode while dispatching
  assign dispatch     = (state_r == ST_DISPATCH);
  assign is_ins       = (op_r == OP_INSERT);
  assign area_sel     = (sel_r == LIST_AREA) || (sel_r == LIST_AREA_FILT);
  assign area_rank_ok = (32'(rank_r) < AREA_DEPTH);
  assign glob_rank_ok = (32'(rank_r) < GLOBAL_DEPTH);
  assign glob_ins     = dispatch && is_ins && hit_r;
  assign glob_f_ins   = glob_ins && pass_r;
  assign area_rd      = dispatch && !is_ins && area_sel && hit_r && area_rank_ok;

  assign cmd_u = '{ins_go: glob_ins, rd_go: area_rd, wr_en: 1'b1};
  assign cmd_f = '{ins_go: glob_ins, rd_go: area_rd, wr_en: pass_r};

  assign glob_sel_rd = (sel_r == LIST_GLOBAL) ? g_rd : gf_rd;

  rtkl_glist #(.DEPTH(GLOBAL_DEPTH)) u_glist (
    .clk       (clk),
    .rst_n     (rst_n),
    .ins       (glob_ins),
    .ins_entry (entry_r),
    .rd_idx    (GIDX_W'(rank_r)),
    .rd_entry  (g_rd)
  );

  rtkl_glist #(.DEPTH(GLOBAL_DEPTH)) u_glist_filt (
    .clk       (clk),
    .rst_n     (rst_n),
    .ins       (glob_f_ins),
    .ins_entry (entry_r),
    .rd_idx    (GIDX_W'(rank_r)),
    .rd_entry  (gf_rd)
  );

  rtkl_astore #(.AREA_DEPTH(AREA_DEPTH), .AREA_COUNT(AREA_COUNT)) u_astore (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_u),
    .row       (ROW_W'(row_r)),
    .slot      (SLOT_W'(rank_r)),
    .ins_entry (entry_r),
    .done      (done_u),
    .rd_entry  (u_rd)
  );

  rtkl_astore #(.AREA_DEPTH(AREA_DEPTH), .AREA_COUNT(AREA_COUNT)) u_astore_filt (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_f),
    .row       (ROW_W'(row_r)),
    .slot      (SLOT_W'(rank_r)),
    .ins_entry (entry_r),
    .done      (done_f),
    .rd_entry  (f_rd)
  );

  // Sequencer with registered result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          out_valid_r <= 1'b0;
          if (start) begin
            state_r <= ST_DISPATCH;
            op_r    <= in_operation;
            entry_r <= '{count: in_thread_count, tag: in_thread_tag, board: in_board_id};
            pass_r  <= in_passes_filter;
            sel_r   <= in_list_select;
            rank_r  <= in_rank;
            hit_r   <= in_map.hit && (32'(in_map.row) < AREA_COUNT);
            row_r   <= in_map.row;
          end
        end
        ST_DISPATCH: begin
          if (is_ins) begin
            if (!hit_r) begin
              out_valid_r  <= 1'b1;
              out_status_r <= STATUS_UNKNOWN;
              out_entry_r  <= '0;
              state_r      <= ST_IDLE;
            end else begin
              out_valid_r <= 1'b0;
              state_r     <= ST_WAIT;
            end
          end else if (!area_sel) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
            if (glob_rank_ok) begin
              out_status_r <= STATUS_OK;
              out_entry_r  <= glob_sel_rd;
            end else begin
              out_status_r <= STATUS_RANGE;
              out_entry_r  <= '0;
            end
          end else if (!hit_r) begin
            out_valid_r  <= 1'b1;
            out_status_r <= STATUS_UNKNOWN;
            out_entry_r  <= '0;
            state_r      <= ST_IDLE;
          end else if (!area_rank_ok) begin
            out_valid_r  <= 1'b1;
            out_status_r <= STATUS_RANGE;
            out_entry_r  <= '0;
            state_r      <= ST_IDLE;
          end else begin
            out_valid_r <= 1'b0;
            state_r     <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (done_u && done_f) begin
            out_valid_r  <= 1'b1;
            out_status_r <= STATUS_OK;
            state_r      <= ST_IDLE;
            if (is_ins) begin
              out_entry_r <= '0;
            end else if (sel_r == LIST_AREA) begin
              out_entry_r <= u_rd;
            end else begin
              out_entry_r <= f_rd;
            end
          end else begin
            out_valid_r <= 1'b0;
          end
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_entry_r.count;
  assign out_entry_tag   = out_entry_r.tag;
  assign out_entry_board = out_entry_r.board;

  // Checks
  `RTKL_ASSERT(a_result_after_busy, clk, rst_n, out_valid |-> $past(busy))
  `RTKL_ASSERT_NEXT(a_no_result_after_accept, clk, rst_n, start && !busy, !out_valid)
  `RTKL_ASSERT(a_stores_lockstep, clk, rst_n, done_u == done_f)
  `RTKL_ASSERT(a_error_fields_zero, clk, rst_n, (out_valid && out_status != STATUS_OK) |-> (out_entry_r == '0))

endmodule
